// ===== rtl/pctw_pkg.sv =====
// Shared types for the decision-tree packet classifier.
// Holds the input and result beat layouts and the node store word layout.
// No dependencies.
package pctw_pkg;

  localparam int ActWrite    = 0;
  localparam int ActClassify = 1;

  typedef struct packed {
    logic        action;
    logic [11:0] node_addr;
    logic        node_internal;
    logic [2:0]  node_dim;
    logic [31:0] node_thresh;
    logic [11:0] node_child;
    logic [31:0] dim_value_0;
    logic [31:0] dim_value_1;
    logic [31:0] dim_value_2;
    logic [31:0] dim_value_3;
    logic [31:0] dim_value_4;
  } pctw_in_t;

  typedef struct packed {
    logic [31:0] rule_index;
    logic        walk_fault;
  } pctw_out_t;

  typedef struct packed {
    logic        internal;
    logic [2:0]  dim;
    logic [11:0] child;
    logic [31:0] thresh;
  } pctw_node_t;

  localparam int NodeW = $bits(pctw_node_t);

endpackage

// ===== rtl/pctw_in_if.sv =====
// Input channel of the classifier: valid/ready plus one input beat.
// Depends on pctw_pkg.
interface pctw_in_if;
  import pctw_pkg::*;

  logic     valid;
  logic     ready;
  pctw_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pctw_out_if.sv =====
// Result channel of the classifier: valid/ready plus one result beat.
// Depends on pctw_pkg.
interface pctw_out_if;
  import pctw_pkg::*;

  logic      valid;
  logic      ready;
  pctw_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pctw_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module pctw_ram #(
  parameter int Width = 48,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pctw_walk.sv =====
// Tree walk sequencer: node writes, one node read and compare per level,
// and the result register. Depends on pctw_pkg, pctw_in_if, pctw_out_if.
module pctw_walk #(
  parameter int NODE_COUNT = 4096,
  parameter int MAX_WALK   = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pctw_in_if.sink                       in_i,
  pctw_out_if.source                    out_o,
  output logic                          ram_we_o,
  output logic                          ram_re_o,
  output logic [$clog2(NODE_COUNT)-1:0] ram_addr_o,
  output logic [pctw_pkg::NodeW-1:0]    ram_wdata_o,
  input  logic [pctw_pkg::NodeW-1:0]    ram_rdata_i
);
  import pctw_pkg::*;

  localparam int AddrW = $clog2(NODE_COUNT);
  localparam int CntW  = $clog2(MAX_WALK + 1);

  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] passed_q, passed_d;
  logic [31:0]     dim_q [5];
  logic            out_valid_q, out_valid_d;
  pctw_out_t       out_q, out_d;

  logic        accept;
  logic        is_classify;
  logic        wr_ok;
  logic [31:0] wr_addr_w;
  pctw_node_t  node;
  logic [31:0] sel_val;
  logic        go_right;
  logic [31:0] next_w;
  logic        leave_store;
  logic        step_limit;
  logic        finish;
  logic        out_free;

  assign in_i.ready  = (state_q == StIdle);
  assign accept      = in_i.valid && in_i.ready;
  assign is_classify = (in_i.data.action == 1'(ActClassify));
  assign wr_addr_w   = 32'(in_i.data.node_addr);
  assign wr_ok       = wr_addr_w < 32'(NODE_COUNT);

  assign node = pctw_node_t'(ram_rdata_i);

  always_comb begin
    unique case (node.dim)
      3'd0:    sel_val = dim_q[0];
      3'd1:    sel_val = dim_q[1];
      3'd2:    sel_val = dim_q[2];
      3'd3:    sel_val = dim_q[3];
      3'd4:    sel_val = dim_q[4];
      default: sel_val = '0;
    endcase
  end

  assign go_right    = sel_val > node.thresh;
  assign next_w      = 32'(node.child) + 32'(go_right);
  assign leave_store = next_w >= 32'(NODE_COUNT);
  assign step_limit  = passed_q == CntW'(MAX_WALK);
  assign finish      = !node.internal || step_limit || leave_store;
  assign out_free    = !out_valid_q || out_o.ready;

  assign ram_wdata_o = {in_i.data.node_internal, in_i.data.node_dim,
                        in_i.data.node_child, in_i.data.node_thresh};

  always_comb begin
    state_d     = state_q;
    passed_d    = passed_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = wr_addr_w[AddrW-1:0];
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (is_classify) begin
            ram_re_o   = 1'b1;
            ram_addr_o = '0;
            passed_d   = '0;
            state_d    = StWalk;
          end else begin
            ram_we_o = wr_ok;
          end
        end
      end
      StWalk: begin
        if (finish) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            if (!node.internal) begin
              out_d.rule_index = node.thresh;
              out_d.walk_fault = 1'b0;
            end else begin
              out_d.rule_index = '0;
              out_d.walk_fault = 1'b1;
            end
            state_d = StIdle;
          end
        end else begin
          ram_re_o   = 1'b1;
          ram_addr_o = next_w[AddrW-1:0];
          passed_d   = passed_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      passed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      passed_q    <= passed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept && is_classify) begin
      dim_q[0] <= in_i.data.dim_value_0;
      dim_q[1] <= in_i.data.dim_value_1;
      dim_q[2] <= in_i.data.dim_value_2;
      dim_q[3] <= in_i.data.dim_value_3;
      dim_q[4] <= in_i.data.dim_value_4;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ===== rtl/packet_classify_tree_walk_core.sv =====
// Decision-tree packet classifier top level: node store RAM and walk sequencer.
// A classify beat makes one read of the single-port node RAM per level of the walk.
// A new beat is taken once the walk has loaded the result register.
// Reset clears control state only; node store contents stay undefined until
// written, and no clearing pass runs. Depends on pctw_pkg, pctw_in_if,
// pctw_out_if, pctw_ram, pctw_walk.
module packet_classify_tree_walk_core #(
  parameter int NODE_COUNT = 4096,
  parameter int MAX_WALK   = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pctw_in_if.sink    in_i,
  pctw_out_if.source out_o
);
  import pctw_pkg::*;

  localparam int AddrW = $clog2(NODE_COUNT);

  logic             ram_we;
  logic             ram_re;
  logic [AddrW-1:0] ram_addr;
  logic [NodeW-1:0] ram_wdata;
  logic [NodeW-1:0] ram_rdata;

  pctw_walk #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_WALK   (MAX_WALK)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  pctw_ram #(
    .Width (NodeW),
    .Depth (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
